### design/odo_pkg.sv
// Package for the differential-drive odometry block: widths, step codes,
// command and status structs, CORDIC angle table and saturation helper.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package odo_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int WIN_AW = $clog2(MAX_WINDOW);
  localparam int WIN_CW = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = 32 + WIN_AW + 1;

  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;

  localparam int DIV_NW = 56;
  localparam int DIV_DW = 32;
  localparam int DIVN_W = DIV_NW + 1;
  localparam int DIVD_W = DIV_DW + 1;
  localparam int DIVQ_W = DIV_NW + 1;
  localparam int DIV_CW = $clog2(DIV_NW);

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W = 34;
  localparam int CORDIC_IW = $clog2(CORDIC_STEPS);
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [MUL_W-1:0] TURN_PER_RAD = 34'sd683565276;
  localparam logic [31:0] MIN_INTERVAL = 32'd1678;

  localparam logic [1:0] REG_SEP = 2'd0;
  localparam logic [1:0] REG_LRAD = 2'd1;
  localparam logic [1:0] REG_RRAD = 2'd2;
  localparam logic [1:0] REG_WIN = 2'd3;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] ST_IDLE       = 5'd0;
  localparam logic [STEP_W-1:0] ST_MUL_L      = 5'd1;
  localparam logic [STEP_W-1:0] ST_MUL_R      = 5'd2;
  localparam logic [STEP_W-1:0] ST_DIFF       = 5'd3;
  localparam logic [STEP_W-1:0] ST_ANG_DIV    = 5'd4;
  localparam logic [STEP_W-1:0] ST_ANG_WAIT   = 5'd5;
  localparam logic [STEP_W-1:0] ST_OPEN_V     = 5'd6;
  localparam logic [STEP_W-1:0] ST_OPEN_W     = 5'd7;
  localparam logic [STEP_W-1:0] ST_OPEN_END   = 5'd8;
  localparam logic [STEP_W-1:0] ST_MUL_D      = 5'd9;
  localparam logic [STEP_W-1:0] ST_DH         = 5'd10;
  localparam logic [STEP_W-1:0] ST_COR_H      = 5'd11;
  localparam logic [STEP_W-1:0] ST_COR_H_WAIT = 5'd12;
  localparam logic [STEP_W-1:0] ST_SF_DIV     = 5'd13;
  localparam logic [STEP_W-1:0] ST_SF_WAIT    = 5'd14;
  localparam logic [STEP_W-1:0] ST_COR_M      = 5'd15;
  localparam logic [STEP_W-1:0] ST_COR_M_WAIT = 5'd16;
  localparam logic [STEP_W-1:0] ST_MUL_CT     = 5'd17;
  localparam logic [STEP_W-1:0] ST_MUL_SU     = 5'd18;
  localparam logic [STEP_W-1:0] ST_MUL_LT     = 5'd19;
  localparam logic [STEP_W-1:0] ST_MUL_LU     = 5'd20;
  localparam logic [STEP_W-1:0] ST_POSE_Y     = 5'd21;
  localparam logic [STEP_W-1:0] ST_LSPD_DIV   = 5'd22;
  localparam logic [STEP_W-1:0] ST_LSPD_WAIT  = 5'd23;
  localparam logic [STEP_W-1:0] ST_ASPD_DIV   = 5'd24;
  localparam logic [STEP_W-1:0] ST_ASPD_WAIT  = 5'd25;
  localparam logic [STEP_W-1:0] ST_PUSH       = 5'd26;
  localparam logic [STEP_W-1:0] ST_RL_DIV     = 5'd27;
  localparam logic [STEP_W-1:0] ST_RL_WAIT    = 5'd28;
  localparam logic [STEP_W-1:0] ST_RA_DIV     = 5'd29;
  localparam logic [STEP_W-1:0] ST_RA_WAIT    = 5'd30;
  localparam logic [STEP_W-1:0] ST_DONE       = 5'd31;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              load;
  } odo_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cor_done;
    logic sep_zero;
    logic ang_zero;
    logic speed_path;
    logic out_free;
  } odo_sts_t;

  function automatic logic [29:0] atan_val(input logic [CORDIC_IW-1:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [WIN_CW-1:0] eff_window(input logic [4:0] ws);
    logic [WIN_CW-1:0] r;
    if (ws == 5'd0) begin
      r = WIN_CW'(1);
    end else if (32'(ws) > MAX_WINDOW) begin
      r = WIN_CW'(MAX_WINDOW);
    end else begin
      r = WIN_CW'(ws);
    end
    return r;
  endfunction

endpackage

### design/odo_div.sv
// Restoring divider with round-to-nearest, ties away from zero, one quotient
// bit per cycle. Depends on odo_pkg.
`timescale 1ns / 1ps
module odo_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [odo_pkg::DIVN_W-1:0]  num,
  input  logic signed [odo_pkg::DIVD_W-1:0]  den,
  output logic                               done,
  output logic signed [odo_pkg::DIVQ_W-1:0]  quot
);
  import odo_pkg::*;

  logic                busy_r, done_r, neg_r;
  logic [DIV_CW-1:0]   cnt_r;
  logic [DIV_NW-1:0]   dvd_r;
  logic [DIV_DW-1:0]   ud_r, rem_r;
  logic [DIVN_W-1:0]   un_full;
  logic [DIVD_W-1:0]   ud_full;
  logic [DIV_DW:0]     rem_sh, rem_sub;
  logic                q_bit;

  always_comb begin
    un_full = num[DIVN_W-1] ? DIVN_W'(-num) : DIVN_W'(num);
    ud_full = den[DIVD_W-1] ? DIVD_W'(-den) : DIVD_W'(den);
    rem_sh  = {rem_r, dvd_r[DIV_NW-1]};
    rem_sub = rem_sh - {1'b0, ud_r};
    q_bit   = rem_sh >= {1'b0, ud_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= un_full[DIV_NW-1:0] + DIV_NW'(ud_full[DIV_DW-1:1]);
      ud_r  <= ud_full[DIV_DW-1:0];
      rem_r <= '0;
      neg_r <= num[DIVN_W-1] ^ den[DIVD_W-1];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_NW-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
    end
  end

  assign done = done_r;
  assign quot = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

endmodule

### design/odo_cordic.sv
// Iterative rotation CORDIC giving sine and cosine in Q1.30 of a 32-bit binary angle,
// one micro-rotation per cycle. Depends on odo_pkg.
`timescale 1ns / 1ps
module odo_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [31:0]                         angle,
  output logic                                done,
  output logic signed [odo_pkg::CORDIC_W-1:0] sin_o,
  output logic signed [odo_pkg::CORDIC_W-1:0] cos_o
);
  import odo_pkg::*;

  logic                       busy_r, done_r, flip_r;
  logic [CORDIC_IW-1:0]       i_r;
  logic signed [CORDIC_W-1:0] x_r, y_r, z_r, at;
  logic [31:0]                a_fold;
  logic                       flip_nxt;

  always_comb begin
    flip_nxt = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
    a_fold   = flip_nxt ? {~angle[31], angle[30:0]} : angle;
    at       = $signed({{(CORDIC_W-30){1'b0}}, atan_val(i_r)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == CORDIC_IW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_GAIN;
      y_r    <= '0;
      z_r    <= CORDIC_W'($signed(a_fold));
      flip_r <= flip_nxt;
    end else if (busy_r) begin
      if (!z_r[CORDIC_W-1]) begin
        x_r <= x_r - (y_r >>> i_r);
        y_r <= y_r + (x_r >>> i_r);
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + (y_r >>> i_r);
        y_r <= y_r - (x_r >>> i_r);
        z_r <= z_r + at;
      end
    end
  end

  assign done  = done_r;
  assign cos_o = flip_r ? -x_r : x_r;
  assign sin_o = flip_r ? -y_r : y_r;

endmodule

### design/odo_dp.sv
// Odometry datapath: configuration registers, shared multiplier, pose and
// speed-window state, output register. Uses odo_div, odo_cordic and odo_pkg.
`timescale 1ns / 1ps
module odo_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  odo_pkg::odo_cmd_t  cmd,
  output odo_pkg::odo_sts_t  sts,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  input  logic               in_opcode,
  input  logic signed [31:0] in_left_wheel_angle,
  input  logic signed [31:0] in_right_wheel_angle,
  input  logic [31:0]        in_interval,
  input  logic signed [31:0] in_open_linear_speed,
  input  logic signed [31:0] in_open_angular_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_heading,
  output logic signed [31:0] out_mean_linear_speed,
  output logic signed [31:0] out_mean_angular_speed,
  output logic               out_speed_updated
);
  import odo_pkg::*;

  logic [17:0]              sep_r;
  logic [15:0]              lrad_r, rrad_r;
  logic [4:0]               wsize_r;
  logic                     opc_r;
  logic signed [31:0]       angl_r, angr_r, vl_r, va_r;
  logic [31:0]              dt_r;
  logic signed [31:0]       prev_l_r, prev_r_r, lc_r, lin_r, ang_r;
  logic signed [33:0]       diff_r, t_r, u_r;
  logic signed [31:0]       x_r, y_r, lspd_r, aspd_r, rep_l_r, rep_a_r;
  logic [31:0]              hd_r, d_r, h_r;
  logic signed [32:0]       sf_r;
  logic signed [SUM_W-1:0]  sum_l_r, sum_a_r, sum_l_nxt, sum_a_nxt;
  logic signed [31:0]       win_l_r [MAX_WINDOW];
  logic signed [31:0]       win_a_r [MAX_WINDOW];
  logic [WIN_AW-1:0]        pos_r, pos_eff, pos_nxt;
  logic [WIN_CW-1:0]        fill_r, fill_nxt, win_n, pos_inc;
  logic                     win_full;
  logic signed [PROD_W-1:0] prod_r, rs16, rs17, rs24, rs30;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [32:0]       dl, dr;
  logic signed [34:0]       lin_sum;
  logic signed [31:0]       rc_sat, lin_c;
  logic signed [33:0]       diff_c;
  logic                     div_start, div_done, cor_start, cor_done;
  logic signed [DIVN_W-1:0] div_num;
  logic signed [DIVD_W-1:0] div_den;
  logic signed [DIVQ_W-1:0] div_q;
  logic [31:0]              cor_angle;
  logic signed [CORDIC_W-1:0] cor_sin, cor_cos;
  logic                     out_valid_r, out_upd_r, out_free;
  logic signed [31:0]       out_x_r, out_y_r, out_ml_r, out_ma_r;
  logic [31:0]              out_hd_r;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    rs16    = (prod_r + (68'sd1 <<< 15)) >>> 16;
    rs17    = (prod_r + (68'sd1 <<< 16)) >>> 17;
    rs24    = (prod_r + (68'sd1 <<< 23)) >>> 24;
    rs30    = (prod_r + (68'sd1 <<< 29)) >>> 30;
    rc_sat  = sat32(rs16);
    dl      = 33'(lc_r) - 33'(prev_l_r);
    dr      = 33'(rc_sat) - 33'(prev_r_r);
    lin_sum = 35'(dl) + 35'(dr) + 35'sd1;
    lin_c   = sat32(68'(lin_sum >>> 1));
    diff_c  = 34'(dr) - 34'(dl);
  end

  always_comb begin
    win_n     = eff_window(wsize_r);
    pos_eff   = (WIN_CW'(pos_r) >= win_n) ? '0 : pos_r;
    win_full  = fill_r >= win_n;
    sum_l_nxt = sum_l_r + SUM_W'(lspd_r) - (win_full ? SUM_W'(win_l_r[pos_eff]) : '0);
    sum_a_nxt = sum_a_r + SUM_W'(aspd_r) - (win_full ? SUM_W'(win_a_r[pos_eff]) : '0);
    pos_inc   = WIN_CW'(pos_eff) + 1'b1;
    pos_nxt   = (pos_inc == win_n) ? '0 : pos_inc[WIN_AW-1:0];
    fill_nxt  = win_full ? fill_r : fill_r + 1'b1;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      ST_MUL_L: begin
        mul_a = MUL_W'(angl_r);
        mul_b = $signed({{(MUL_W-16){1'b0}}, lrad_r});
      end
      ST_MUL_R: begin
        mul_a = MUL_W'(angr_r);
        mul_b = $signed({{(MUL_W-16){1'b0}}, rrad_r});
      end
      ST_OPEN_V: begin
        mul_a = MUL_W'(vl_r);
        mul_b = $signed({{(MUL_W-32){1'b0}}, dt_r});
      end
      ST_OPEN_W: begin
        mul_a = MUL_W'(va_r);
        mul_b = $signed({{(MUL_W-32){1'b0}}, dt_r});
      end
      ST_MUL_D: begin
        mul_a = MUL_W'(ang_r);
        mul_b = TURN_PER_RAD;
      end
      ST_MUL_CT: begin
        mul_a = MUL_W'(cor_cos);
        mul_b = MUL_W'(sf_r);
      end
      ST_MUL_SU: begin
        mul_a = MUL_W'(cor_sin);
        mul_b = MUL_W'(sf_r);
      end
      ST_MUL_LT: begin
        mul_a = MUL_W'(lin_r);
        mul_b = t_r;
      end
      ST_MUL_LU: begin
        mul_a = MUL_W'(lin_r);
        mul_b = u_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd.step)
      ST_ANG_DIV: begin
        div_start = (sep_r != '0);
        div_num   = DIVN_W'(diff_r) <<< 16;
        div_den   = $signed({{(DIVD_W-18){1'b0}}, sep_r});
      end
      ST_SF_DIV: begin
        div_num = DIVN_W'(cor_sin) <<< 17;
        div_den = DIVD_W'(ang_r);
      end
      ST_LSPD_DIV: begin
        div_num = DIVN_W'(lin_r) <<< 24;
        div_den = $signed({1'b0, dt_r});
      end
      ST_ASPD_DIV: begin
        div_num = DIVN_W'(ang_r) <<< 24;
        div_den = $signed({1'b0, dt_r});
      end
      ST_RL_DIV: begin
        div_num = DIVN_W'(sum_l_r);
        div_den = $signed({{(DIVD_W-WIN_CW){1'b0}}, fill_r});
      end
      ST_RA_DIV: begin
        div_num = DIVN_W'(sum_a_r);
        div_den = $signed({{(DIVD_W-WIN_CW){1'b0}}, fill_r});
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    cor_start = (cmd.step == ST_COR_H) || (cmd.step == ST_COR_M);
    cor_angle = (cmd.step == ST_COR_H) ? h_r : hd_r + h_r;
  end

  odo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  odo_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .sin_o (cor_sin),
    .cos_o (cor_cos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r       <= 18'd65536;
      lrad_r      <= '0;
      rrad_r      <= '0;
      wsize_r     <= 5'd10;
      prev_l_r    <= '0;
      prev_r_r    <= '0;
      x_r         <= '0;
      y_r         <= '0;
      hd_r        <= '0;
      rep_l_r     <= '0;
      rep_a_r     <= '0;
      sum_l_r     <= '0;
      sum_a_r     <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SEP:  sep_r  <= cfg_data;
          REG_LRAD: lrad_r <= cfg_data[15:0];
          REG_RRAD: rrad_r <= cfg_data[15:0];
          REG_WIN: begin
            wsize_r <= cfg_data[4:0];
            pos_r   <= '0;
            fill_r  <= '0;
            sum_l_r <= '0;
            sum_a_r <= '0;
          end
          default: begin
          end
        endcase
      end
      unique case (cmd.step)
        ST_DIFF: begin
          prev_l_r <= lc_r;
          prev_r_r <= rc_sat;
        end
        ST_OPEN_END: begin
          rep_l_r <= vl_r;
          rep_a_r <= va_r;
        end
        ST_MUL_LU: x_r <= sat32(68'(x_r) + rs30);
        ST_POSE_Y: begin
          y_r  <= sat32(68'(y_r) + rs30);
          hd_r <= hd_r + d_r;
        end
        ST_PUSH: begin
          sum_l_r <= sum_l_nxt;
          sum_a_r <= sum_a_nxt;
          pos_r   <= pos_nxt;
          fill_r  <= fill_nxt;
        end
        ST_RL_WAIT: if (div_done) rep_l_r <= sat32(68'(div_q));
        ST_RA_WAIT: if (div_done) rep_a_r <= sat32(68'(div_q));
        default: begin
        end
      endcase
      if (cmd.step == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.load) begin
      opc_r  <= in_opcode;
      angl_r <= in_left_wheel_angle;
      angr_r <= in_right_wheel_angle;
      dt_r   <= in_interval;
      vl_r   <= in_open_linear_speed;
      va_r   <= in_open_angular_speed;
    end
    unique case (cmd.step)
      ST_MUL_R: lc_r <= sat32(rs16);
      ST_DIFF: begin
        lin_r  <= lin_c;
        diff_r <= diff_c;
      end
      ST_ANG_DIV: begin
        if (sep_r == '0) begin
          if (diff_r > 34'sd0) begin
            ang_r <= 32'sh7FFFFFFF;
          end else if (diff_r < 34'sd0) begin
            ang_r <= 32'sh80000000;
          end else begin
            ang_r <= '0;
          end
        end
      end
      ST_ANG_WAIT:  if (div_done) ang_r <= sat32(68'(div_q));
      ST_OPEN_W:    lin_r <= sat32(rs24);
      ST_OPEN_END:  ang_r <= sat32(rs24);
      ST_DH: begin
        d_r  <= rs16[31:0];
        h_r  <= rs17[31:0];
        sf_r <= 33'sd1 <<< 30;
      end
      ST_SF_WAIT:   if (div_done) sf_r <= $signed(div_q[32:0]);
      ST_MUL_SU:    t_r <= rs30[33:0];
      ST_MUL_LT:    u_r <= rs30[33:0];
      ST_LSPD_WAIT: if (div_done) lspd_r <= sat32(68'(div_q));
      ST_ASPD_WAIT: if (div_done) aspd_r <= sat32(68'(div_q));
      ST_PUSH: begin
        win_l_r[pos_eff] <= lspd_r;
        win_a_r[pos_eff] <= aspd_r;
      end
      ST_DONE: begin
        if (out_free) begin
          out_x_r   <= x_r;
          out_y_r   <= y_r;
          out_hd_r  <= hd_r;
          out_ml_r  <= rep_l_r;
          out_ma_r  <= rep_a_r;
          out_upd_r <= opc_r || (dt_r >= MIN_INTERVAL);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.div_done   = div_done;
    sts.cor_done   = cor_done;
    sts.sep_zero   = (sep_r == '0);
    sts.ang_zero   = (ang_r == '0);
    sts.speed_path = !opc_r && (dt_r >= MIN_INTERVAL);
    sts.out_free   = out_free;
  end

  assign out_valid              = out_valid_r;
  assign out_pos_x              = out_x_r;
  assign out_pos_y              = out_y_r;
  assign out_heading            = out_hd_r;
  assign out_mean_linear_speed  = out_ml_r;
  assign out_mean_angular_speed = out_ma_r;
  assign out_speed_updated      = out_upd_r;

endmodule

### design/odo_ctrl.sv
// Odometry controller: sequences the datapath through one word's steps and
// waits on the divider, CORDIC and output register. Depends on odo_pkg.
`timescale 1ns / 1ps
module odo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_ready,
  input  odo_pkg::odo_sts_t sts,
  output odo_pkg::odo_cmd_t cmd
);
  import odo_pkg::*;

  logic [STEP_W-1:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);
  assign cmd.step = state_r;
  assign cmd.load = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = in_opcode ? ST_OPEN_V : ST_MUL_L;
      ST_MUL_L:      state_nxt = ST_MUL_R;
      ST_MUL_R:      state_nxt = ST_DIFF;
      ST_DIFF:       state_nxt = ST_ANG_DIV;
      ST_ANG_DIV:    state_nxt = sts.sep_zero ? ST_MUL_D : ST_ANG_WAIT;
      ST_ANG_WAIT:   if (sts.div_done) state_nxt = ST_MUL_D;
      ST_OPEN_V:     state_nxt = ST_OPEN_W;
      ST_OPEN_W:     state_nxt = ST_OPEN_END;
      ST_OPEN_END:   state_nxt = ST_MUL_D;
      ST_MUL_D:      state_nxt = ST_DH;
      ST_DH:         state_nxt = sts.ang_zero ? ST_COR_M : ST_COR_H;
      ST_COR_H:      state_nxt = ST_COR_H_WAIT;
      ST_COR_H_WAIT: if (sts.cor_done) state_nxt = ST_SF_DIV;
      ST_SF_DIV:     state_nxt = ST_SF_WAIT;
      ST_SF_WAIT:    if (sts.div_done) state_nxt = ST_COR_M;
      ST_COR_M:      state_nxt = ST_COR_M_WAIT;
      ST_COR_M_WAIT: if (sts.cor_done) state_nxt = ST_MUL_CT;
      ST_MUL_CT:     state_nxt = ST_MUL_SU;
      ST_MUL_SU:     state_nxt = ST_MUL_LT;
      ST_MUL_LT:     state_nxt = ST_MUL_LU;
      ST_MUL_LU:     state_nxt = ST_POSE_Y;
      ST_POSE_Y:     state_nxt = sts.speed_path ? ST_LSPD_DIV : ST_DONE;
      ST_LSPD_DIV:   state_nxt = ST_LSPD_WAIT;
      ST_LSPD_WAIT:  if (sts.div_done) state_nxt = ST_ASPD_DIV;
      ST_ASPD_DIV:   state_nxt = ST_ASPD_WAIT;
      ST_ASPD_WAIT:  if (sts.div_done) state_nxt = ST_PUSH;
      ST_PUSH:       state_nxt = ST_RL_DIV;
      ST_RL_DIV:     state_nxt = ST_RL_WAIT;
      ST_RL_WAIT:    if (sts.div_done) state_nxt = ST_RA_DIV;
      ST_RA_DIV:     state_nxt = ST_RA_WAIT;
      ST_RA_WAIT:    if (sts.div_done) state_nxt = ST_DONE;
      ST_DONE:       if (sts.out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r != ST_IDLE))
    else $error("accepted word did not start processing");

  a_ang_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ANG_WAIT && !sts.div_done) |=> (state_r == ST_ANG_WAIT))
    else $error("left divider wait before quotient was ready");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !sts.out_free) |=> (state_r == ST_DONE))
    else $error("result dropped while output register was full");

endmodule

### design/differential_drive_odometry.sv
// Top level of the differential-drive odometry block: wires the controller,
// the datapath and the configuration port. Depends on odo_pkg, odo_ctrl, odo_dp.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     opcode, wheel angles, interval, speeds
//   out      output     out_valid / out_ready   pose, heading, mean speeds, update flag
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// The time from one accepted word to the next is shortest in open loop with no turn, grows with a turn,
// and is longest in closed loop with a speed update; it is set by the divider (six uses)
// and the CORDIC unit (two uses).
// Reset is synchronous and active low; the speed windows need no clearing pass.
// A finished result waits in the output register while the next word is taken.
`timescale 1ns / 1ps
module differential_drive_odometry (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_left_wheel_angle,
  input  logic signed [31:0] in_right_wheel_angle,
  input  logic [31:0]        in_interval,
  input  logic signed [31:0] in_open_linear_speed,
  input  logic signed [31:0] in_open_angular_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_heading,
  output logic signed [31:0] out_mean_linear_speed,
  output logic signed [31:0] out_mean_angular_speed,
  output logic               out_speed_updated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data
);
  import odo_pkg::*;

  odo_cmd_t cmd;
  odo_sts_t sts;

  assign cfg_ready = 1'b1;

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  odo_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_opcode              (in_opcode),
    .in_left_wheel_angle    (in_left_wheel_angle),
    .in_right_wheel_angle   (in_right_wheel_angle),
    .in_interval            (in_interval),
    .in_open_linear_speed   (in_open_linear_speed),
    .in_open_angular_speed  (in_open_angular_speed),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_pos_x              (out_pos_x),
    .out_pos_y              (out_pos_y),
    .out_heading            (out_heading),
    .out_mean_linear_speed  (out_mean_linear_speed),
    .out_mean_angular_speed (out_mean_angular_speed),
    .out_speed_updated      (out_speed_updated)
  );

endmodule
